[design/slr_pkg.sv]
package slr_pkg;

  typedef logic [29:0] value_t;

  localparam int TableLen = 55;
  localparam int TrailTap = 31;     // trail entry sits 31 cells ahead of lead
  localparam int FillStride = 21;   // table positions advance by 21 during fill
  localparam int FillSlot = 33;     // cell loaded during fill so the ring ends aligned
  localparam int MixCycles = 4 * TableLen;

  localparam value_t Modulus = 30'd1000000000;
  localparam logic [27:0] SeedBase = 28'd161803398;

  typedef struct packed {
    logic fill;   // rotate by the stride and load one new entry
    logic shift;  // rotate by one, lead cell replaced by the difference
  } ctrl_t;

  // (a - b) mod one billion, both operands below one billion
  function automatic value_t sub_mod(input value_t a, input value_t b);
    value_t r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a + Modulus - b;
    end
    return r;
  endfunction

endpackage

[design/subtractive_lagged_random_unit.sv]
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o   operation_i, seed_magnitude_i
// out      output     out_valid_o/out_stall_i random_value_o
//
// A plain draw goes straight into the output register; items may follow back to back.
// A rebuild (seed item, or first item after reset) runs through the accept, then 55 fill
// steps, 220 mixing steps, then the draw, one ring rotation per fill, mixing or draw step.
// Reset clears control only; the ring is loaded by the first rebuild.
// Input stalls while a rebuild runs or while the output register is held.
module subtractive_lagged_random_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [27:0] seed_magnitude_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [29:0] random_value_o
);
  import slr_pkg::*;

  ctrl_t  ctrl;
  value_t load_val;
  value_t diff;
  value_t ring [TableLen];

  // cell 0 holds the lead entry, the trail entry is a fixed tap
  assign diff = sub_mod(ring[0], ring[TrailTap]);

  slr_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .seed_magnitude_i (seed_magnitude_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .random_value_o   (random_value_o),
    .diff_i           (diff),
    .ctrl_o           (ctrl),
    .load_val_o       (load_val)
  );

  for (genvar k = 0; k < TableLen; k++) begin : g_cell
    localparam int Next = (k + 1) % TableLen;
    localparam int Jump = (k + FillStride) % TableLen;

    slr_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .load_i     (k == FillSlot),
      .load_val_i (load_val),
      .shift_in_i ((k == TableLen - 1) ? diff : ring[Next]),
      .jump_in_i  (ring[Jump]),
      .val_o      (ring[k])
    );
  end

endmodule

[design/slr_cell.sv]
module slr_cell (
  input  logic           clk_i,
  input  slr_pkg::ctrl_t ctrl_i,
  input  logic           load_i,
  input  slr_pkg::value_t load_val_i,
  input  slr_pkg::value_t shift_in_i,
  input  slr_pkg::value_t jump_in_i,
  output slr_pkg::value_t val_o
);
  import slr_pkg::*;

  value_t val_d, val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.fill) begin
      val_d = load_i ? load_val_i : jump_in_i;
    end else if (ctrl_i.shift) begin
      val_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

[design/slr_ctrl.sv]
module slr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  logic [27:0]     seed_magnitude_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [29:0]     random_value_o,
  input  slr_pkg::value_t diff_i,
  output slr_pkg::ctrl_t  ctrl_o,
  output slr_pkg::value_t load_val_o
);
  import slr_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StFill,
    StMix,
    StDraw
  } state_e;

  state_e      state_q;
  logic [7:0]  cnt_q;
  logic        seeded_q;
  logic        out_valid_q;
  value_t      value_q;
  value_t      gen_x_q, gen_y_q;

  logic        out_free;
  logic        accept;
  logic        rebuild;
  logic        load_out;
  logic [27:0] seed_sat;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && state_q == StIdle && out_free;
  assign rebuild  = operation_i || !seeded_q;
  assign seed_sat = (seed_magnitude_i > SeedBase) ? SeedBase : seed_magnitude_i;
  // a draw result enters the output register this cycle
  assign load_out = (accept && !rebuild) || (state_q == StDraw && out_free);

  always_comb begin
    ctrl_o.fill  = (state_q == StFill);
    ctrl_o.shift = load_out || (state_q == StMix);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      gen_x_q     <= '0;
      gen_y_q     <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        value_q     <= diff_i;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept && rebuild) begin
            state_q <= StFill;
            cnt_q   <= '0;
            gen_x_q <= value_t'(SeedBase - seed_sat);
            gen_y_q <= value_t'(1);
          end
        end
        StFill: begin
          gen_x_q <= gen_y_q;
          gen_y_q <= sub_mod(gen_x_q, gen_y_q);
          if (cnt_q == 8'(TableLen - 1)) begin
            state_q <= StMix;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 8'd1;
          end
        end
        StMix: begin
          if (cnt_q == 8'(MixCycles - 1)) begin
            state_q  <= StDraw;
            seeded_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 8'd1;
          end
        end
        StDraw: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o     = !(state_q == StIdle && out_free);
  assign out_valid_o    = out_valid_q;
  assign random_value_o = value_q;
  assign load_val_o     = gen_x_q;

endmodule

[bench/slr_bench_pkg.sv]
package slr_bench_pkg;

  typedef enum logic {
    OpDraw   = 1'b0,
    OpReseed = 1'b1
  } op_e;

  // largest seed that keeps the first table value non-negative
  localparam logic [27:0] SeedTop = 28'd161803398;

endpackage

[bench/slr_checker.sv]
module slr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        operation_i,
  input  logic [27:0] seed_magnitude_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [29:0] random_value_o,
  output int          fail_count_o,
  output int          pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import slr_pkg::*;
  import slr_bench_pkg::*;

  localparam value_t Billion = 30'd1000000000;
  localparam int RingLen = 55;
  localparam int FillStride = 21;
  localparam int MixLag = 31;
  localparam logic [5:0] LeadStart = 6'd0;
  localparam logic [5:0] TrailStart = 6'd31;

  value_t     ring [1:RingLen];
  logic [5:0] lead_idx = LeadStart;
  logic [5:0] trail_idx = TrailStart;
  logic       ring_built = 1'b0;
  value_t     queued_draws [$];
  value_t     want;

  initial begin
    fail_count_o = 0;
    pending_count_o = 0;
  end

  function automatic value_t wrap_sub(input value_t a, input value_t b);
    value_t d;
    if (a >= b) begin
      d = a - b;
    end else begin
      d = a + Billion - b;
    end
    return d;
  endfunction

  function automatic logic [5:0] bump_idx(input logic [5:0] idx);
    return (idx >= RingLen) ? 6'd1 : idx + 6'd1;
  endfunction

  function automatic void build_ring(input logic [27:0] seed);
    value_t prev, cur;
    int     i, pass, pos;
    // oversized seeds clamp, so the first entry bottoms out at zero
    prev = (seed > SeedTop) ? '0 : value_t'(SeedTop - seed);
    cur = 30'd1;
    ring[RingLen] = prev;
    for (i = 1; i < RingLen; i++) begin
      pos = (FillStride * i) % RingLen;
      ring[pos] = cur;
      cur = wrap_sub(prev, cur);
      prev = ring[pos];
    end
    for (pass = 0; pass < 4; pass++) begin
      for (i = 1; i <= RingLen; i++) begin
        ring[i] = wrap_sub(ring[i], ring[1 + (i + MixLag - 1) % RingLen]);
      end
    end
    lead_idx = LeadStart;
    trail_idx = TrailStart;
    ring_built = 1'b1;
  endfunction

  function automatic value_t next_draw(input op_e op, input logic [27:0] seed);
    value_t v;
    // first item after reset rebuilds even on a plain draw
    if (op == OpReseed || !ring_built) begin
      build_ring(seed);
    end
    lead_idx = bump_idx(lead_idx);
    trail_idx = bump_idx(trail_idx);
    v = wrap_sub(ring[lead_idx], ring[trail_idx]);
    ring[lead_idx] = v;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_idx = LeadStart;
      trail_idx = TrailStart;
      ring_built = 1'b0;
      queued_draws.delete();
    end else begin
      if (in_valid_i && !in_stall_o) begin
        queued_draws.push_back(next_draw(op_e'(operation_i), seed_magnitude_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (queued_draws.size() == 0) begin
          $display("%0t: random_value expected none, got %0d", $time, random_value_o);
          fail_count_o++;
        end else begin
          want = queued_draws.pop_front();
          if (random_value_o !== want) begin
            $display("%0t: random_value expected %0d, got %0d",
                     $time, want, random_value_o);
            fail_count_o++;
          end
        end
      end
    end
    pending_count_o = queued_draws.size();
  end

endmodule

[bench/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slr_pkg::*;
  import slr_bench_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int PhaseItems = 584;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        operation_i;
  logic [27:0] seed_magnitude_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [29:0] random_value_o;

  int          fail_count;
  int          pending_count;
  int          tx_idle_pct = 17;
  int          rx_idle_pct = 51;
  int          results_taken = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;

  subtractive_lagged_random_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .seed_magnitude_i (seed_magnitude_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .random_value_o   (random_value_o)
  );

  slr_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .seed_magnitude_i (seed_magnitude_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .random_value_o   (random_value_o),
    .fail_count_o     (fail_count),
    .pending_count_o  (pending_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall, plus one long hold once 300 results are in
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      results_taken <= results_taken + 1;
    end
    if (out_valid_o && !out_stall_i && results_taken == 299) begin
      hold_left <= 80;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // valid stays high after acceptance; callers lower it before a pause
  task automatic send_item(input op_e op, input logic [27:0] seed);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    seed_magnitude_i <= seed;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
  endtask

  function automatic logic [27:0] pick_seed();
    logic [27:0] s;
    case ($urandom_range(5))
      0: s = 28'd0;
      1: s = SeedTop;
      2: s = SeedTop + 28'd1 + 28'($urandom_range(1000));
      3: s = 28'($urandom);
      default: s = 28'($urandom_range(SeedTop));
    endcase
    return s;
  endfunction

  initial begin
    int phase, n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OpDraw;
    seed_magnitude_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // plain draw right after reset must still build the table
    send_item(OpDraw, 28'd12345);
    send_item(OpDraw, 28'hFFFFFFF);
    send_item(OpDraw, 28'd0);
    send_item(OpReseed, 28'd0);
    send_item(OpDraw, 28'd7);
    send_item(OpDraw, 28'hAAAAAAA);
    send_item(OpDraw, 28'h5555555);
    send_item(OpReseed, SeedTop);
    send_item(OpDraw, 28'd0);
    send_item(OpReseed, SeedTop + 28'd1);
    send_item(OpDraw, 28'd0);
    send_item(OpReseed, 28'hFFFFFFF);
    send_item(OpReseed, SeedTop - 28'd1);
    send_item(OpReseed, 28'd1);
    send_item(OpReseed, 28'h5555555);
    send_item(OpReseed, 28'hAAAAAAA);
    for (n = 0; n < 6; n++) begin
      send_item(OpDraw, 28'($urandom));
    end
    drain();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 17;
          rx_idle_pct = 51;
        end
        1: begin
          tx_idle_pct = 51;
          rx_idle_pct = 17;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(39) == 0) begin
          send_item(OpReseed, pick_seed());
        end else begin
          send_item(OpDraw, 28'($urandom));
        end
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
